### rtl/swmf_pkg.sv
// Shared types, constants and helpers for the sliding-window mode filter.
// Used by swmf_hist and sliding_window_mode_filter; depends on nothing else.
package swmf_pkg;

  // Window and class range
  localparam int WINDOW      = 10;
  localparam int NUM_CLASSES = 32;

  // Field and storage widths
  localparam int LABEL_W = 5;
  localparam int CNT_W   = 4;
  localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int HEAD_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W  = $clog2(WINDOW + 1);
  localparam int SCAN_W  = $clog2(NUM_CLASSES + 1);

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [LABEL_W-1:0] ZSUB_RESET = LABEL_W'(21);
  localparam logic REG_ZSUB = 1'b0;  // word index of zero_substitute

  // Count limits
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Request from the sequencer to the histogram store
  typedef struct packed {
    logic             rd_en;
    logic [CLS_W-1:0] rd_addr;
    logic             wr_en;
    logic [CLS_W-1:0] wr_addr;
    logic [CNT_W-1:0] wr_data;
  } hist_req_t;

  // Saturate a label into the class range
  function automatic logic [LABEL_W-1:0] clamp_class(input logic [LABEL_W-1:0] v);
    logic [LABEL_W-1:0] r;
    r = v;
    if (int'(v) >= NUM_CLASSES) r = LABEL_W'(NUM_CLASSES - 1);
    return r;
  endfunction

endpackage

### rtl/swmf_hist.sv
// Per-label histogram store: one write and one registered read per cycle.
// Entries read as zero until first written after reset. Depends on swmf_pkg.
module swmf_hist (
  input  logic                       clk,
  input  logic                       rst,
  input  swmf_pkg::hist_req_t        req,
  output logic [swmf_pkg::CNT_W-1:0] rd_data
);

  logic [swmf_pkg::CNT_W-1:0]       mem [swmf_pkg::NUM_CLASSES];
  logic [swmf_pkg::NUM_CLASSES-1:0] valid;

  // Mark entries as written; reset empties the whole histogram at once
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= valid[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

endmodule

### rtl/sliding_window_mode_filter.sv
// Top level of the sliding-window mode filter: sequencer, label ring, output
// register and configuration port. Depends on swmf_pkg and swmf_hist.
//
// Usage:
//   Input beats on s_tvalid/s_tready/s_tdata carry one classifier label each.
//   A zero label is replaced by the zero_substitute register (APB, offset 0,
//   reset 21). Each label enters a ring of the last 10 labels, evicting the
//   oldest once full, and the histogram of per-label counts follows it.
//   Every input beat gives one output beat on m_tvalid/m_tready/m_tdata with
//   the most frequent label in the window, the lowest label winning ties.
//   The sequencer steps through the eviction read and write (once the ring is
//   full), the add read and write, a scan of the 32 counters through the
//   single histogram read port, one counter a cycle, and a finish state that
//   loads the output register. s_tready is high only while the sequencer is
//   idle, so one label is in flight at a time and a new label is taken only
//   once the previous one has left the sequencer.
//   A finished result waits in the output register; the next label may be
//   taken meanwhile, and the sequencer holds its result until m_tready frees
//   the register. Reset empties the ring and histogram and restores the
//   substitute register; no clearing pass is needed.
module sliding_window_mode_filter (
  input  logic                        clk,
  input  logic                        rst,
  // Input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [4:0] label, [7:5] zero
  // Output stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,   // [4:0] mode_label, [7:5] zero
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swmf_pkg::ADDR_W-1:0] paddr,
  input  logic [swmf_pkg::DATA_W-1:0] pwdata,
  output logic [swmf_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVICT_RD,
    ST_EVICT_WR,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                          state;
  logic [swmf_pkg::LABEL_W-1:0]    zero_substitute;
  logic [swmf_pkg::LABEL_W-1:0]    window_ring [swmf_pkg::WINDOW];
  logic [swmf_pkg::HEAD_W-1:0]     ring_head;
  logic [swmf_pkg::FILL_W-1:0]     fill_count;
  logic [swmf_pkg::CLS_W-1:0]      new_addr;
  logic [swmf_pkg::CLS_W-1:0]      old_addr;
  logic [swmf_pkg::SCAN_W-1:0]     scan_addr;
  logic                            cmp_vld;
  logic [swmf_pkg::CLS_W-1:0]      cmp_idx;
  logic [swmf_pkg::CNT_W-1:0]      best_cnt;
  logic [swmf_pkg::CLS_W-1:0]      best_label;
  logic [swmf_pkg::LABEL_W-1:0]    mode_label;

  swmf_pkg::hist_req_t             hreq;
  logic [swmf_pkg::CNT_W-1:0]      hrd_data;

  logic                            in_beat;
  logic                            cfg_wr;
  logic [swmf_pkg::LABEL_W-1:0]    lab_in;
  logic [swmf_pkg::LABEL_W-1:0]    lab_new;
  logic [swmf_pkg::LABEL_W-1:0]    lab_old;
  logic                            ring_full;
  logic                            scan_issue;
  logic                            scan_done;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_substitute <= swmf_pkg::ZSUB_RESET;
    end else if (cfg_wr && (paddr[2] == swmf_pkg::REG_ZSUB)) begin
      zero_substitute <= pwdata[swmf_pkg::LABEL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == swmf_pkg::REG_ZSUB) begin
      prdata = swmf_pkg::DATA_W'(zero_substitute);
    end
  end

  // Label substitution and clamping
  assign lab_in    = s_tdata[swmf_pkg::LABEL_W-1:0];
  assign lab_new   = swmf_pkg::clamp_class((lab_in == '0) ? zero_substitute : lab_in);
  assign lab_old   = swmf_pkg::clamp_class(window_ring[ring_head]);
  assign ring_full = (fill_count == swmf_pkg::FILL_W'(swmf_pkg::WINDOW));
  assign s_tready  = (state == ST_IDLE);
  assign in_beat   = s_tvalid & s_tready;

  // Label ring: write at head on each accepted beat
  always_ff @(posedge clk) begin
    if (in_beat) begin
      window_ring[ring_head] <= lab_new;
    end
  end

  // Scan control
  assign scan_issue = (state == ST_SCAN) &&
                      (scan_addr < swmf_pkg::SCAN_W'(swmf_pkg::NUM_CLASSES));
  assign scan_done  = (state == ST_SCAN) && !scan_issue && !cmp_vld;

  // Histogram requests
  always_comb begin
    hreq = '0;
    case (state)
      ST_EVICT_RD: begin
        hreq.rd_en   = 1'b1;
        hreq.rd_addr = old_addr;
      end
      ST_EVICT_WR: begin
        hreq.wr_en   = (hrd_data != '0);
        hreq.wr_addr = old_addr;
        hreq.wr_data = hrd_data - swmf_pkg::CNT_W'(1);
      end
      ST_ADD_RD: begin
        hreq.rd_en   = 1'b1;
        hreq.rd_addr = new_addr;
      end
      ST_ADD_WR: begin
        hreq.wr_en   = (hrd_data != swmf_pkg::CNT_MAX);
        hreq.wr_addr = new_addr;
        hreq.wr_data = hrd_data + swmf_pkg::CNT_W'(1);
      end
      ST_SCAN: begin
        hreq.rd_en   = scan_issue;
        hreq.rd_addr = scan_addr[swmf_pkg::CLS_W-1:0];
      end
      default: hreq = '0;
    endcase
  end

  swmf_hist u_hist (
    .clk     (clk),
    .rst     (rst),
    .req     (hreq),
    .rd_data (hrd_data)
  );

  // Sequencer, ring pointers, scan compare and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ring_head  <= '0;
      fill_count <= '0;
      cmp_vld    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // Drop the output beat once taken, unless a new one is loaded now
      if (m_tvalid && m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            new_addr  <= swmf_pkg::CLS_W'(lab_new);
            old_addr  <= swmf_pkg::CLS_W'(lab_old);
            ring_head <= (ring_head == swmf_pkg::HEAD_W'(swmf_pkg::WINDOW - 1)) ?
                         '0 : ring_head + swmf_pkg::HEAD_W'(1);
            if (!ring_full) begin
              fill_count <= fill_count + swmf_pkg::FILL_W'(1);
            end
            state <= ring_full ? ST_EVICT_RD : ST_ADD_RD;
          end
        end
        ST_EVICT_RD: state <= ST_EVICT_WR;
        ST_EVICT_WR: state <= ST_ADD_RD;
        ST_ADD_RD:   state <= ST_ADD_WR;
        ST_ADD_WR: begin
          scan_addr  <= '0;
          cmp_vld    <= 1'b0;
          best_cnt   <= '0;
          best_label <= '0;
          state      <= ST_SCAN;
        end
        ST_SCAN: begin
          // Issue one read a cycle; compare the returned count in the next cycle
          cmp_vld <= scan_issue;
          cmp_idx <= scan_addr[swmf_pkg::CLS_W-1:0];
          if (scan_issue) begin
            scan_addr <= scan_addr + swmf_pkg::SCAN_W'(1);
          end
          if (cmp_vld && (hrd_data > best_cnt)) begin
            best_cnt   <= hrd_data;
            best_label <= cmp_idx;
          end
          if (scan_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Hold the result until the output register is free
          if (!m_tvalid || m_tready) begin
            mode_label <= swmf_pkg::LABEL_W'(best_label);
            m_tvalid   <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {3'b000, mode_label};

  // Fill count never passes the window length
  assert property (@(posedge clk) disable iff (rst)
    fill_count <= swmf_pkg::FILL_W'(swmf_pkg::WINDOW))
    else $error("fill count beyond window");

  // Ring head stays inside the ring
  assert property (@(posedge clk) disable iff (rst)
    ring_head < swmf_pkg::HEAD_W'(swmf_pkg::WINDOW))
    else $error("ring head out of range");

  // An accepted beat takes the sequencer out of idle
  assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !s_tready)
    else $error("input taken while busy");

  // Eviction only happens once the ring is full
  assert property (@(posedge clk) disable iff (rst)
    (in_beat && !ring_full) |=> (state == ST_ADD_RD))
    else $error("eviction before ring full");

endmodule

### verif/tb_sliding_window_mode_filter.sv
// Self-checking testbench for sliding_window_mode_filter: drives label beats, the
// substitute register over APB, and checks each mode label against a built-in predictor.
// Depends on swmf_pkg and the RTL of sliding_window_mode_filter.
module tb_sliding_window_mode_filter;

  localparam int TDATA_W        = 8;
  localparam int REG_COUNT      = 1;     // registers in the map
  localparam int SETTLE_CYCLES  = 45;    // worst input-to-output latency plus margin
  localparam int LONG_HOLD      = 600;   // receiver hold-off in the pressure test
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no beat before giving up
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 230;
  localparam int TAIL_ITEMS     = 100;

  localparam logic [swmf_pkg::ADDR_W-1:0] ZSUB_ADDR  =
    swmf_pkg::ADDR_W'(4 * int'(swmf_pkg::REG_ZSUB));
  localparam logic [swmf_pkg::ADDR_W-1:0] SPARE_ADDR = swmf_pkg::ADDR_W'(4 * REG_COUNT);

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [TDATA_W-1:0]            s_tdata;   // [4:0] label, [7:5] zero
  logic                          m_tvalid;
  logic                          m_tready;
  logic [TDATA_W-1:0]            m_tdata;   // [4:0] mode_label, [7:5] zero
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [swmf_pkg::ADDR_W-1:0]   paddr;
  logic [swmf_pkg::DATA_W-1:0]   pwdata;
  logic [swmf_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  sliding_window_mode_filter uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: label window, histogram and substitute register
  logic [swmf_pkg::LABEL_W-1:0] window_labels [swmf_pkg::WINDOW];
  logic [swmf_pkg::HEAD_W-1:0]  window_head;
  logic [swmf_pkg::FILL_W-1:0]  window_fill;
  logic [swmf_pkg::CNT_W-1:0]   class_counts [swmf_pkg::NUM_CLASSES];
  logic [swmf_pkg::LABEL_W-1:0] zsub_shadow;

  logic [swmf_pkg::LABEL_W-1:0] expected_modes [$];

  int  fail_count;
  int  labels_sent;
  int  modes_checked;
  int  reg_writes;
  bit  tx_idle;          // sender may leave gaps
  bit  rx_idle;          // receiver may stall
  bit  offering;         // s_tvalid is being held high
  int  hold_request;     // long receiver hold-off asked by a test
  int  rx_stall_left;
  int  quiet_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the window by one label and return the expected mode
  function automatic logic [swmf_pkg::LABEL_W-1:0] advance_window(
    input logic [swmf_pkg::LABEL_W-1:0] raw);
    logic [swmf_pkg::LABEL_W-1:0] lab;
    logic [swmf_pkg::LABEL_W-1:0] evicted;
    logic [swmf_pkg::LABEL_W-1:0] best;
    logic [swmf_pkg::CNT_W-1:0]   best_n;
    lab = (raw == '0) ? zsub_shadow : raw;
    if (int'(lab) >= swmf_pkg::NUM_CLASSES)
      lab = swmf_pkg::LABEL_W'(swmf_pkg::NUM_CLASSES - 1);
    // evict the oldest label once the window is full
    if (int'(window_fill) >= swmf_pkg::WINDOW) begin
      evicted = window_labels[window_head];
      if (int'(evicted) >= swmf_pkg::NUM_CLASSES)
        evicted = swmf_pkg::LABEL_W'(swmf_pkg::NUM_CLASSES - 1);
      if (class_counts[evicted] != '0) class_counts[evicted] = class_counts[evicted] - 1'b1;
    end else begin
      window_fill = window_fill + 1'b1;
    end
    window_labels[window_head] = lab;
    if (class_counts[lab] != swmf_pkg::CNT_MAX) class_counts[lab] = class_counts[lab] + 1'b1;
    window_head = (int'(window_head) + 1 >= swmf_pkg::WINDOW) ? '0 : window_head + 1'b1;
    // scan upwards; only a strictly larger count displaces, so ties keep the lowest
    best   = '0;
    best_n = class_counts[0];
    for (int c = 1; c < swmf_pkg::NUM_CLASSES; c++) begin
      if (class_counts[c] > best_n) begin
        best_n = class_counts[c];
        best   = swmf_pkg::LABEL_W'(c);
      end
    end
    return best;
  endfunction

  // Offer one label beat and predict its mode on acceptance
  task automatic send_label(input logic [swmf_pkg::LABEL_W-1:0] lab);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_W'(lab);
    offering  = 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_modes = {expected_modes, advance_window(lab)};
    labels_sent++;
    // drop valid for a random burst now and then
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid <= 1'b0;
      s_tdata  <= TDATA_W'($urandom_range(0, 31));
      offering  = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lower valid after the last beat of a phase
  task automatic end_stream();
    if (offering) begin
      s_tvalid <= 1'b0;
      offering  = 1'b0;
    end
  endtask

  // Wait for every expected mode, then let the block go idle
  task automatic settle_block();
    end_stream();
    while (expected_modes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup phase, then access phase until pready, then an idle phase
  task automatic write_reg(input logic [swmf_pkg::ADDR_W-1:0] addr,
                           input logic [swmf_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ZSUB_ADDR) zsub_shadow = value[swmf_pkg::LABEL_W-1:0];
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Label with a bias towards a few recurring classes so the mode moves around
  function automatic logic [swmf_pkg::LABEL_W-1:0] pick_label(
    input logic [swmf_pkg::LABEL_W-1:0] pool [3]);
    if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, 2)];
    return swmf_pkg::LABEL_W'($urandom_range(0, 31));
  endfunction

  // Window fill, ties, substitution at reset value and eviction
  task automatic test_fill_and_ties();
    logic [swmf_pkg::LABEL_W-1:0] seq [14] = '{5'd31, 5'd1, 5'd31, 5'd0, 5'd21, 5'd21,
                                               5'd16, 5'd8, 5'd4, 5'd2, 5'd1, 5'd1,
                                               5'd1, 5'd1};
    foreach (seq[i]) send_label(seq[i]);
    settle_block();
  endtask

  // Zero substitute at both extremes, and a write to an unmapped address
  task automatic test_zero_substitute();
    write_reg(ZSUB_ADDR, '0);
    repeat (3) send_label('0);
    settle_block();
    write_reg(ZSUB_ADDR, swmf_pkg::DATA_W'(31));
    repeat (4) send_label('0);
    settle_block();
    write_reg(SPARE_ADDR, swmf_pkg::DATA_W'(5));
    send_label('0);
    send_label(5'd5);
    settle_block();
    write_reg(ZSUB_ADDR, swmf_pkg::DATA_W'(swmf_pkg::ZSUB_RESET));
  endtask

  // Receiver holds off for a long stretch while labels keep coming
  task automatic test_backpressure();
    tx_idle      = 1'b0;
    rx_idle      = 1'b0;
    hold_request = LONG_HOLD;
    for (int i = 0; i < 12; i++) send_label(swmf_pkg::LABEL_W'($urandom_range(0, 31)));
    settle_block();
  endtask

  // Random labels over several substitute settings with idling on both sides
  task automatic test_random_labels();
    logic [swmf_pkg::LABEL_W-1:0] pool [3];
    logic [swmf_pkg::DATA_W-1:0]  zsub;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       zsub = '0;
        1:       zsub = swmf_pkg::DATA_W'(31);
        2:       zsub = swmf_pkg::DATA_W'(swmf_pkg::ZSUB_RESET);
        default: zsub = $urandom;
      endcase
      write_reg(ZSUB_ADDR, zsub);
      if (phase == 3) write_reg(SPARE_ADDR, $urandom);
      tx_idle = (phase % 3) != 1;
      rx_idle = (phase % 3) != 2;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 20 == 0)
          foreach (pool[k]) pool[k] = swmf_pkg::LABEL_W'($urandom_range(0, 31));
        send_label(pick_label(pool));
      end
      settle_block();
    end
    // last stretch runs flat out
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (int i = 0; i < TAIL_ITEMS; i++)
      send_label(swmf_pkg::LABEL_W'($urandom_range(0, 31)));
    settle_block();
  endtask

  // Receiver: random stall bursts, plus the long hold-off on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (rx_stall_left > 0) begin
        m_tready <= 1'b0;
        rx_stall_left--;
      end else if (hold_request > 0) begin
        m_tready     <= 1'b0;
        rx_stall_left = hold_request - 1;
        hold_request  = 0;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        m_tready     <= 1'b0;
        rx_stall_left = $urandom_range(1, 18) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each mode beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_modes.size() == 0) begin
        $error("mode_label: unexpected beat, actual %0d", m_tdata[swmf_pkg::LABEL_W-1:0]);
        fail_count++;
      end else begin
        if (m_tdata[swmf_pkg::LABEL_W-1:0] !== expected_modes[0]) begin
          $error("mode_label: expected %0d, actual %0d",
                 expected_modes[0], m_tdata[swmf_pkg::LABEL_W-1:0]);
          fail_count++;
        end
        void'(expected_modes.pop_front());
        modes_checked++;
      end
    end
  end

  // Watchdog: give up after a long run of cycles with no beat anywhere
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (psel && penable && pwrite && pready) || rst)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Main sequence
  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    fail_count    = 0;
    labels_sent   = 0;
    modes_checked = 0;
    reg_writes    = 0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    offering      = 1'b0;
    hold_request  = 0;
    rx_stall_left = 0;
    // predictor starts from the reset state
    foreach (window_labels[i]) window_labels[i] = '0;
    foreach (class_counts[i]) class_counts[i] = '0;
    window_head = '0;
    window_fill = '0;
    zsub_shadow = swmf_pkg::ZSUB_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_and_ties();
    test_zero_substitute();
    test_backpressure();
    test_random_labels();

    $display("Covered %0d labels, %0d mode beats checked, %0d register writes,",
             labels_sent, modes_checked, reg_writes);
    $display("with substitute values at both extremes, ties, eviction and backpressure.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/swmf_pkg.sv
rtl/swmf_hist.sv
rtl/sliding_window_mode_filter.sv
verif/tb_sliding_window_mode_filter.sv
